FILE: rtl/lbsrc_pkg.sv
package lbsrc_pkg;

    localparam int WORD_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_CORNERS   = 8;

    // quotient bits resolved per divider stage
    localparam int DIV_STEPS = 2;
    localparam int DIV_NSTG  = WORD_W / DIV_STEPS;
    // prep register, step stages, saturation register
    localparam int DIV_LAT   = DIV_NSTG + 2;

    localparam logic signed [WORD_W-1:0] W_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] W_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_VP_X_LO  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_VP_X_HI  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_VP_Y_LO  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_VP_Y_HI  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_VP_W_LO  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_VP_W_HI  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_CAM_XY   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_CAM_Z    = 3'd7;

endpackage

FILE: rtl/lbsrc_div.sv
module lbsrc_div #(
    parameter int FRAC_BITS = lbsrc_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [lbsrc_pkg::WORD_W-1:0] num_i,
    input  logic signed [lbsrc_pkg::WORD_W-1:0] den_i,
    output logic signed [lbsrc_pkg::WORD_W-1:0] quo_o
);
    import lbsrc_pkg::*;

    logic [WORD_W-1:0] mag;
    logic [WORD_W-1:0] hi_part;
    logic              ovf_next;
    logic              nonpos_next;

    logic [WORD_W-1:0] rem_reg    [0:DIV_NSTG];
    logic [WORD_W-1:0] nlo_reg    [0:DIV_NSTG];
    logic [WORD_W-1:0] q_reg      [0:DIV_NSTG];
    logic [WORD_W-1:0] den_reg    [0:DIV_NSTG];
    logic              neg_reg    [0:DIV_NSTG];
    logic              ovf_reg    [0:DIV_NSTG];
    logic              nonpos_reg [0:DIV_NSTG];

    logic signed [WORD_W-1:0] quo_next;

    // magnitude of the numerator scaled by 2^FRAC_BITS; the part above the
    // low word seeds the remainder, and if it already reaches w the quotient
    // cannot fit a word
    always_comb begin
        mag         = num_i[WORD_W-1] ? (~num_i + 1'b1) : num_i;
        hi_part     = mag >> (WORD_W - FRAC_BITS);
        ovf_next    = (hi_part >= den_i);
        nonpos_next = den_i[WORD_W-1] || (den_i == '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]    <= ovf_next ? '0 : hi_part;
            nlo_reg[0]    <= mag << FRAC_BITS;
            q_reg[0]      <= '0;
            den_reg[0]    <= den_i;
            neg_reg[0]    <= num_i[WORD_W-1];
            ovf_reg[0]    <= ovf_next;
            nonpos_reg[0] <= nonpos_next;
        end
    end

    for (genvar s = 0; s < DIV_NSTG; s++) begin : g_stage
        logic [WORD_W-1:0] rem_next;
        logic [WORD_W-1:0] nlo_next;
        logic [WORD_W-1:0] q_next;
        logic [WORD_W:0]   trial;

        always_comb begin
            rem_next = rem_reg[s];
            nlo_next = nlo_reg[s];
            q_next   = q_reg[s];
            trial    = '0;
            for (int t = 0; t < DIV_STEPS; t++) begin
                trial    = {rem_next, nlo_next[WORD_W-1]};
                nlo_next = nlo_next << 1;
                if (trial >= {1'b0, den_reg[s]}) begin
                    trial    = trial - {1'b0, den_reg[s]};
                    q_next   = {q_next[WORD_W-2:0], 1'b1};
                end else begin
                    q_next   = {q_next[WORD_W-2:0], 1'b0};
                end
                rem_next = trial[WORD_W-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s+1]    <= rem_next;
                nlo_reg[s+1]    <= nlo_next;
                q_reg[s+1]      <= q_next;
                den_reg[s+1]    <= den_reg[s];
                neg_reg[s+1]    <= neg_reg[s];
                ovf_reg[s+1]    <= ovf_reg[s];
                nonpos_reg[s+1] <= nonpos_reg[s];
            end
        end
    end

    // saturate; zero or negative w goes to the rail of the numerator's sign
    always_comb begin
        priority if (nonpos_reg[DIV_NSTG]) begin
            quo_next = neg_reg[DIV_NSTG] ? W_MIN : W_MAX;
        end else if (!neg_reg[DIV_NSTG]) begin
            quo_next = (ovf_reg[DIV_NSTG] || q_reg[DIV_NSTG][WORD_W-1]) ?
                       W_MAX : q_reg[DIV_NSTG];
        end else begin
            quo_next = (ovf_reg[DIV_NSTG] || (q_reg[DIV_NSTG] > W_MIN)) ?
                       W_MIN : (~q_reg[DIV_NSTG] + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_o <= quo_next;
        end
    end

endmodule

FILE: rtl/light_box_screen_rect_cull.sv
// Screen-rectangle cull of one light's axis-aligned box.
// Input channel s_*: one box per word (lower and upper corners, signed
// fixed point). Result channel m_*: visible, camera_inside and the screen
// rectangle in normalised device units. Configuration goes through the APB
// port: the x, y and w rows of the view-projection matrix and the camera
// position, one 64-bit register every 8 bytes; write it only while idle.
// Throughput: one box per cycle while m_ready does not stall the output.
// The path from accept to m_valid runs through the multiply, sum and
// saturate stages, the pipelined dividers (two quotient bits per stage by
// default) and the min/max tree.
// Reset clears every valid bit and the configuration registers; boxes in
// flight are dropped. When the receiver holds m_ready low with a word
// waiting, the whole pipeline freezes and s_ready falls; nothing is lost
// or repeated, and s_ready rises again as soon as the waiting word goes.
module light_box_screen_rect_cull #(
    parameter int FRAC_BITS = lbsrc_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [5:0]                          paddr,
    input  logic [63:0]                         pwdata,
    output logic [63:0]                         prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [lbsrc_pkg::WORD_W-1:0] s_box_min_x,
    input  logic signed [lbsrc_pkg::WORD_W-1:0] s_box_min_y,
    input  logic signed [lbsrc_pkg::WORD_W-1:0] s_box_min_z,
    input  logic signed [lbsrc_pkg::WORD_W-1:0] s_box_max_x,
    input  logic signed [lbsrc_pkg::WORD_W-1:0] s_box_max_y,
    input  logic signed [lbsrc_pkg::WORD_W-1:0] s_box_max_z,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_visible,
    output logic                                m_camera_inside,
    output logic signed [lbsrc_pkg::WORD_W-1:0] m_rect_min_x,
    output logic signed [lbsrc_pkg::WORD_W-1:0] m_rect_min_y,
    output logic signed [lbsrc_pkg::WORD_W-1:0] m_rect_max_x,
    output logic signed [lbsrc_pkg::WORD_W-1:0] m_rect_max_y
);
    import lbsrc_pkg::*;

    localparam int PROD_W   = 2 * WORD_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int PIPE_LEN = 3 + DIV_LAT + 2;
    localparam logic signed [WORD_W-1:0] ONE     = WORD_W'(1) << FRAC_BITS;
    localparam logic signed [WORD_W-1:0] NEG_ONE = -ONE;

    // ---------------- configuration ----------------
    logic [63:0]         cfg_reg [0:6];
    logic [WORD_W-1:0]   camz_reg;
    logic [REG_IDX_W-1:0] widx;

    assign pready = 1'b1;
    assign widx   = paddr[5:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 7; i++) begin
                cfg_reg[i] <= '0;
            end
            camz_reg <= '0;
        end else if (psel && penable && pwrite) begin
            if (widx == REG_CAM_Z) begin
                camz_reg <= pwdata[WORD_W-1:0];
            end else begin
                cfg_reg[widx] <= pwdata;
            end
        end
    end

    always_comb begin
        unique case (widx)
            REG_VP_X_LO: prdata = cfg_reg[0];
            REG_VP_X_HI: prdata = cfg_reg[1];
            REG_VP_Y_LO: prdata = cfg_reg[2];
            REG_VP_Y_HI: prdata = cfg_reg[3];
            REG_VP_W_LO: prdata = cfg_reg[4];
            REG_VP_W_HI: prdata = cfg_reg[5];
            REG_CAM_XY:  prdata = cfg_reg[6];
            REG_CAM_Z:   prdata = {32'd0, camz_reg};
            default:     prdata = '0;
        endcase
    end

    // matrix entries m[row][e], rows x, y, w
    logic signed [WORD_W-1:0] mtx [0:2][0:3];
    logic signed [WORD_W-1:0] cam [0:2];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            mtx[r][0] = cfg_reg[2*r][WORD_W-1:0];
            mtx[r][1] = cfg_reg[2*r][63:32];
            mtx[r][2] = cfg_reg[2*r+1][WORD_W-1:0];
            mtx[r][3] = cfg_reg[2*r+1][63:32];
        end
        cam[0] = cfg_reg[6][WORD_W-1:0];
        cam[1] = cfg_reg[6][63:32];
        cam[2] = camz_reg;
    end

    // ---------------- flow control ----------------
    logic en;
    logic vld_reg    [0:PIPE_LEN-1];
    logic inside_reg [0:PIPE_LEN-1];

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PIPE_LEN; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < PIPE_LEN; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // ---------------- stage 1: products, camera test ----------------
    logic signed [WORD_W-1:0] lo [0:2];
    logic signed [WORD_W-1:0] hi [0:2];
    logic                     inside_next;
    logic signed [PROD_W-1:0] prod_reg [0:2][0:2][0:1];

    always_comb begin
        lo[0] = s_box_min_x; lo[1] = s_box_min_y; lo[2] = s_box_min_z;
        hi[0] = s_box_max_x; hi[1] = s_box_max_y; hi[2] = s_box_max_z;
        inside_next = 1'b1;
        for (int a = 0; a < 3; a++) begin
            if (!(cam[a] > lo[a] && cam[a] < hi[a])) begin
                inside_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            inside_reg[0] <= inside_next;
            for (int i = 1; i < PIPE_LEN; i++) begin
                inside_reg[i] <= inside_reg[i-1];
            end
            for (int r = 0; r < 3; r++) begin
                for (int a = 0; a < 3; a++) begin
                    prod_reg[r][a][0] <= mtx[r][a] * lo[a];
                    prod_reg[r][a][1] <= mtx[r][a] * hi[a];
                end
            end
        end
    end

    // ---------------- stage 2: exact row sums per corner ----------------
    logic signed [SUM_W-1:0] sum_next [0:NUM_CORNERS-1][0:2];
    logic signed [SUM_W-1:0] sum_reg  [0:NUM_CORNERS-1][0:2];

    always_comb begin
        for (int k = 0; k < NUM_CORNERS; k++) begin
            for (int r = 0; r < 3; r++) begin
                sum_next[k][r] = SUM_W'(prod_reg[r][0][k & 1])
                               + SUM_W'(prod_reg[r][1][(k >> 1) & 1])
                               + SUM_W'(prod_reg[r][2][(k >> 2) & 1])
                               + (SUM_W'(mtx[r][3]) <<< FRAC_BITS);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= sum_next;
        end
    end

    // ---------------- stage 3: floor to fixed point, saturate ----------------
    logic signed [SUM_W-1:0]  shr [0:NUM_CORNERS-1][0:2];
    logic signed [WORD_W-1:0] clip_next [0:NUM_CORNERS-1][0:2];
    logic signed [WORD_W-1:0] clip_reg  [0:NUM_CORNERS-1][0:2];

    always_comb begin
        for (int k = 0; k < NUM_CORNERS; k++) begin
            for (int r = 0; r < 3; r++) begin
                shr[k][r] = sum_reg[k][r] >>> FRAC_BITS;
                if (shr[k][r] > SUM_W'(W_MAX)) begin
                    clip_next[k][r] = W_MAX;
                end else if (shr[k][r] < SUM_W'(W_MIN)) begin
                    clip_next[k][r] = W_MIN;
                end else begin
                    clip_next[k][r] = shr[k][r][WORD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            clip_reg <= clip_next;
        end
    end

    // ---------------- divide by w ----------------
    logic signed [WORD_W-1:0] sx [0:NUM_CORNERS-1];
    logic signed [WORD_W-1:0] sy [0:NUM_CORNERS-1];

    for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_corner
        lbsrc_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
            .aclk  (aclk),
            .en    (en),
            .num_i (clip_reg[k][0]),
            .den_i (clip_reg[k][2]),
            .quo_o (sx[k])
        );
        lbsrc_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
            .aclk  (aclk),
            .en    (en),
            .num_i (clip_reg[k][1]),
            .den_i (clip_reg[k][2]),
            .quo_o (sy[k])
        );
    end

    // ---------------- min/max tree ----------------
    logic signed [WORD_W-1:0] l1_minx_reg [0:3];
    logic signed [WORD_W-1:0] l1_maxx_reg [0:3];
    logic signed [WORD_W-1:0] l1_miny_reg [0:3];
    logic signed [WORD_W-1:0] l1_maxy_reg [0:3];
    logic signed [WORD_W-1:0] l2_minx_reg [0:1];
    logic signed [WORD_W-1:0] l2_maxx_reg [0:1];
    logic signed [WORD_W-1:0] l2_miny_reg [0:1];
    logic signed [WORD_W-1:0] l2_maxy_reg [0:1];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 4; j++) begin
                l1_minx_reg[j] <= (sx[2*j] < sx[2*j+1]) ? sx[2*j] : sx[2*j+1];
                l1_maxx_reg[j] <= (sx[2*j] > sx[2*j+1]) ? sx[2*j] : sx[2*j+1];
                l1_miny_reg[j] <= (sy[2*j] < sy[2*j+1]) ? sy[2*j] : sy[2*j+1];
                l1_maxy_reg[j] <= (sy[2*j] > sy[2*j+1]) ? sy[2*j] : sy[2*j+1];
            end
            for (int j = 0; j < 2; j++) begin
                l2_minx_reg[j] <= (l1_minx_reg[2*j] < l1_minx_reg[2*j+1]) ?
                                  l1_minx_reg[2*j] : l1_minx_reg[2*j+1];
                l2_maxx_reg[j] <= (l1_maxx_reg[2*j] > l1_maxx_reg[2*j+1]) ?
                                  l1_maxx_reg[2*j] : l1_maxx_reg[2*j+1];
                l2_miny_reg[j] <= (l1_miny_reg[2*j] < l1_miny_reg[2*j+1]) ?
                                  l1_miny_reg[2*j] : l1_miny_reg[2*j+1];
                l2_maxy_reg[j] <= (l1_maxy_reg[2*j] > l1_maxy_reg[2*j+1]) ?
                                  l1_maxy_reg[2*j] : l1_maxy_reg[2*j+1];
            end
        end
    end

    // ---------------- output word ----------------
    logic signed [WORD_W-1:0] fminx, fmaxx, fminy, fmaxy;
    logic                     m_valid_reg;
    logic                     visible_reg;
    logic                     inside_out_reg;
    logic signed [WORD_W-1:0] minx_reg, miny_reg, maxx_reg, maxy_reg;

    always_comb begin
        fminx = (l2_minx_reg[0] < l2_minx_reg[1]) ? l2_minx_reg[0] : l2_minx_reg[1];
        fmaxx = (l2_maxx_reg[0] > l2_maxx_reg[1]) ? l2_maxx_reg[0] : l2_maxx_reg[1];
        fminy = (l2_miny_reg[0] < l2_miny_reg[1]) ? l2_miny_reg[0] : l2_miny_reg[1];
        fmaxy = (l2_maxy_reg[0] > l2_maxy_reg[1]) ? l2_maxy_reg[0] : l2_maxy_reg[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vld_reg[PIPE_LEN-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            inside_out_reg <= inside_reg[PIPE_LEN-1];
            if (inside_reg[PIPE_LEN-1]) begin
                visible_reg <= 1'b1;
                minx_reg    <= NEG_ONE;
                miny_reg    <= NEG_ONE;
                maxx_reg    <= ONE;
                maxy_reg    <= ONE;
            end else begin
                // mark not visible when wholly beyond one screen edge
                visible_reg <= !(fmaxx < NEG_ONE || fmaxy < NEG_ONE ||
                                 fminx > ONE || fminy > ONE);
                minx_reg    <= fminx;
                miny_reg    <= fminy;
                maxx_reg    <= fmaxx;
                maxy_reg    <= fmaxy;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_visible       = visible_reg;
    assign m_camera_inside = inside_out_reg;
    assign m_rect_min_x    = minx_reg;
    assign m_rect_min_y    = miny_reg;
    assign m_rect_max_x    = maxx_reg;
    assign m_rect_max_y    = maxy_reg;

    // ---------------- assertions ----------------
    a_inside_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_camera_inside |-> m_visible)
        else $error("camera inside box but word not visible");

    a_inside_rect: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_camera_inside |->
            (m_rect_min_x == NEG_ONE) && (m_rect_max_x == ONE) &&
            (m_rect_min_y == NEG_ONE) && (m_rect_max_y == ONE))
        else $error("camera inside box but rectangle not full screen");

    a_rect_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_camera_inside |->
            (m_rect_min_x <= m_rect_max_x) && (m_rect_min_y <= m_rect_max_y))
        else $error("projected rectangle has min above max");

    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(vld_reg[0]) && $stable(vld_reg[PIPE_LEN-1]))
        else $error("pipeline moved while output stalled");

endmodule
